FILE: sv/obdv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obdv_pkg
// Shared item types and codes for the order book depth and average price block.
// ----------------------------------------------------------------------------
package obdv_pkg;

  typedef enum logic [1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_SNAPSHOT = 2'd1,
    FUNC_EDIT     = 2'd2,
    FUNC_QUERY    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_LIQ   = 2'd1,
    ST_ZERO_TGT = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam int AVG_W = 40;
  localparam int CNT_W = 7;

  typedef struct packed {
    logic [1:0]  func;
    logic        side;
    logic [31:0] price;
    logic [31:0] volume;
    logic [31:0] target_volume;
  } in_item_t;

  typedef struct packed {
    logic [AVG_W-1:0] avg_price;
    logic [1:0]       status;
    logic [CNT_W-1:0] level_count;
  } out_item_t;

endpackage

FILE: sv/order_book_depth_vwap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_depth_vwap
// Bid and ask price-level tables with in-place edits and an average fill
// price query.
// ----------------------------------------------------------------------------
// Both sides share one RAM of 2*LEVELS words (price and volume per word); every
// item but clear walks the addressed side one level at a time through that
// single port. Snapshot or edit: the scan reads levels until it finds the slot,
// then the tail is shifted one entry at a time (read, then write) to open or
// close the slot. Query: the levels are walked until the target volume is
// filled, then a restoring divide runs, one quotient bit per cycle; if the
// levels run out first, the query ends with no liquidity. Clear goes from idle
// straight to the done state, which raises the result strobe.
// busy is high from start until the result strobe; the result shows on out_*
// for one cycle with out_valid and cannot be held off by the receiver.
module order_book_depth_vwap
  import obdv_pkg::*;
#(
  parameter int LEVELS      = 64,
  parameter int PRICE_BITS  = 32,
  parameter int VOLUME_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int LW    = $clog2(LEVELS);
  localparam int AW    = LW + 1;
  localparam int NW    = $clog2(LEVELS + 1);
  localparam int WW    = PRICE_BITS + VOLUME_BITS;
  localparam int ACC_W = PRICE_BITS + VOLUME_BITS + LW + 1;
  localparam int DIV_N = ACC_W + 8;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_WALK, S_DIV, S_SHUP_RD, S_SHUP_WR,
    S_SHDN_RD, S_SHDN_WR, S_PUT, S_DONE
  } state_t;

  state_t            state_r;
  logic [NW-1:0]     cnt_r [2];
  logic              side_r;
  func_t             func_r;
  logic [PRICE_BITS-1:0]  price_r;
  logic [VOLUME_BITS-1:0] vol_r, tgt_r, rem_r;
  logic [LW:0]       idx_r;
  logic [LW:0]       pos_r;
  logic              rd_pend_r;
  logic [ACC_W-1:0]  acc_r;
  logic [DIV_N-1:0]  num_r;
  logic [VOLUME_BITS:0] rmd_r;
  logic [$clog2(DIV_N+1)-1:0] bit_r;
  logic              sat_r;
  logic [AVG_W-1:0]  avg_r;
  status_t           st_r;
  logic              ovld_r;
  logic [WW-1:0]     hold_r;
  logic              ins_r;

  logic              we;
  logic [AW-1:0]     addr;
  logic [WW-1:0]     wdata, rdata;
  logic [PRICE_BITS-1:0]  rd_p;
  logic [VOLUME_BITS-1:0] rd_v;
  logic [NW-1:0]     n;
  logic              ahead_new;
  logic [VOLUME_BITS-1:0] take;
  logic [ACC_W-1:0]  prod;
  logic [VOLUME_BITS:0] rsh;
  logic [NW-1:0]     cnt_out;

  obdv_ram #(.WIDTH(WW), .DEPTH(2 * LEVELS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign rd_p = rdata[WW-1:VOLUME_BITS];
  assign rd_v = rdata[VOLUME_BITS-1:0];
  assign n    = cnt_r[side_r];
  // new price strictly better than the stored one
  assign ahead_new = side_r ? (price_r < rd_p) : (price_r > rd_p);
  assign take = (rd_v < rem_r) ? rd_v : rem_r;
  assign prod = ACC_W'(take * rd_p);
  assign rsh  = {rmd_r[VOLUME_BITS-1:0], num_r[DIV_N-1]};

  // RAM port control
  always_comb begin
    we    = 1'b0;
    wdata = {price_r, vol_r};
    addr  = {side_r, idx_r[LW-1:0]};
    case (state_r)
      S_SHUP_WR: begin
        we    = 1'b1;
        wdata = hold_r;
      end
      S_SHDN_WR: begin
        we    = 1'b1;
        wdata = hold_r;
      end
      S_PUT: begin
        we    = 1'b1;
        addr  = {side_r, pos_r[LW-1:0]};
        wdata = ins_r ? {price_r, vol_r} : {hold_r[WW-1:VOLUME_BITS], vol_r};
      end
      default: ;
    endcase
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r[0]  <= '0;
      cnt_r[1]  <= '0;
      ovld_r    <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      ovld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start && !ovld_r) begin
            func_r    <= func_t'(in_item.func);
            side_r    <= in_item.side;
            price_r   <= in_item.price[PRICE_BITS-1:0];
            vol_r     <= in_item.volume[VOLUME_BITS-1:0];
            tgt_r     <= in_item.target_volume[VOLUME_BITS-1:0];
            rem_r     <= in_item.target_volume[VOLUME_BITS-1:0];
            idx_r     <= '0;
            rd_pend_r <= 1'b0;
            acc_r     <= '0;
            avg_r     <= '0;
            st_r      <= ST_OK;
            case (func_t'(in_item.func))
              FUNC_CLEAR: begin
                cnt_r[0] <= '0;
                cnt_r[1] <= '0;
                state_r  <= S_DONE;
              end
              FUNC_SNAPSHOT: begin
                state_r <= (in_item.volume[VOLUME_BITS-1:0] == '0) ? S_DONE : S_SCAN;
              end
              FUNC_EDIT: state_r <= S_SCAN;
              default: begin
                if (in_item.target_volume[VOLUME_BITS-1:0] == '0) begin
                  st_r    <= ST_ZERO_TGT;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_WALK;
                end
              end
            endcase
          end
        end
        // find the first equal price (edit) or the insert slot
        S_SCAN: begin
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
            if (func_r == FUNC_EDIT && rd_p == price_r) begin
              pos_r <= idx_r;
              hold_r <= rdata;
              if (vol_r == '0) begin
                state_r <= S_SHDN_RD;
                idx_r   <= idx_r + 1'b1;
              end else begin
                ins_r   <= 1'b0;
                state_r <= S_PUT;
              end
            end else if (ahead_new) begin
              // sorted table: no equal price can follow this slot
              pos_r <= idx_r;
              if (vol_r == '0) begin
                state_r <= S_DONE;
              end else if (n == NW'(LEVELS)) begin
                st_r <= ST_FULL; state_r <= S_DONE;
              end else begin
                idx_r <= ($bits(idx_r))'(n - 1'b1);
                state_r <= S_SHUP_RD;
              end
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else if (NW'(idx_r) >= n) begin
            pos_r <= idx_r;
            if (func_r == FUNC_EDIT && vol_r == '0) begin
              state_r <= S_DONE;
            end else if (n == NW'(LEVELS)) begin
              st_r <= ST_FULL; state_r <= S_DONE;
            end else begin
              ins_r   <= 1'b1;
              state_r <= S_PUT;
            end
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        // open a slot: copy entries one slot up, starting at the tail
        S_SHUP_RD: begin
          if (idx_r + 1'b1 == pos_r || n == '0) begin
            ins_r   <= 1'b1;
            state_r <= S_PUT;
          end else if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
            hold_r    <= rdata;
            idx_r     <= idx_r + 1'b1;
            state_r   <= S_SHUP_WR;
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        S_SHUP_WR: begin
          if (idx_r == pos_r + 1'b1 || idx_r == '0) begin
            ins_r   <= 1'b1;
            state_r <= S_PUT;
          end else begin
            idx_r   <= idx_r - 2'd2;
            state_r <= S_SHUP_RD;
          end
        end
        // delete: copy entries one slot down
        S_SHDN_RD: begin
          if (NW'(idx_r) >= n) begin
            cnt_r[side_r] <= n - 1'b1;
            state_r <= S_DONE;
          end else if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
            hold_r    <= rdata;
            idx_r     <= idx_r - 1'b1;
            state_r   <= S_SHDN_WR;
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        S_SHDN_WR: begin
          idx_r   <= idx_r + 2'd2;
          state_r <= S_SHDN_RD;
        end
        S_PUT: begin
          if (ins_r) cnt_r[side_r] <= n + 1'b1;
          state_r <= S_DONE;
        end
        // accumulate take * price from the best level
        S_WALK: begin
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
            acc_r <= acc_r + prod;
            rem_r <= rem_r - take;
            idx_r <= idx_r + 1'b1;
          end else if (rem_r == '0) begin
            num_r   <= {acc_r, 8'd0};
            rmd_r   <= '0;
            bit_r   <= '0;
            sat_r   <= 1'b0;
            state_r <= S_DIV;
          end else if (NW'(idx_r) >= n) begin
            st_r    <= ST_NO_LIQ;
            state_r <= S_DONE;
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        // restoring divide, one quotient bit a cycle
        S_DIV: begin
          num_r <= num_r << 1;
          if (rsh >= {1'b0, tgt_r}) begin
            rmd_r <= rsh - {1'b0, tgt_r};
            if (avg_r[AVG_W-1]) sat_r <= 1'b1;
            avg_r <= {avg_r[AVG_W-2:0], 1'b1};
          end else begin
            rmd_r <= rsh;
            if (avg_r[AVG_W-1]) sat_r <= 1'b1;
            avg_r <= {avg_r[AVG_W-2:0], 1'b0};
          end
          bit_r <= bit_r + 1'b1;
          if (bit_r == $bits(bit_r)'(DIV_N - 1)) state_r <= S_DONE;
        end
        S_DONE: begin
          if (sat_r && func_r == FUNC_QUERY && st_r == ST_OK) avg_r <= '1;
          ovld_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE) || ovld_r;
  assign out_valid = ovld_r;
  assign cnt_out   = cnt_r[side_r];
  assign out_item.avg_price   = (st_r == ST_OK && func_r == FUNC_QUERY) ? avg_r : '0;
  assign out_item.status      = st_r;
  assign out_item.level_count = (NW > CNT_W && cnt_out > NW'(127)) ? CNT_W'(127)
                                                                    : CNT_W'(cnt_out);

  // counts never exceed table depth
  a_cnt0: assert property (@(posedge clk) disable iff (!rst_n) cnt_r[0] <= NW'(LEVELS))
    else $error("bid count overflow");
  a_cnt1: assert property (@(posedge clk) disable iff (!rst_n) cnt_r[1] <= NW'(LEVELS))
    else $error("ask count overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
    else $error("result while idle");
  a_one: assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("double result");

endmodule

FILE: sv/obdv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obdv_ram
// Single port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module obdv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read first port, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
